// ===== sv/clnw_pkg.sv =====
// Shared types, codes and constants for the character-LCD nibble writer.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package clnw_pkg;

  // Command codes on the action field
  localparam logic [2:0] ActChar   = 3'd0;
  localparam logic [2:0] ActCursor = 3'd1;
  localparam logic [2:0] ActClear  = 3'd2;
  localparam logic [2:0] ActHome   = 3'd3;
  localparam logic [2:0] ActRaw    = 3'd4;
  localparam logic [2:0] ActInit   = 3'd5;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CfgDisplayLength = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgLineTwoAddr   = 2'd1;

  localparam logic [6:0] DisplayLengthReset = 7'd16;
  localparam logic [6:0] LineTwoAddrReset   = 7'd64;

  // Controller instruction bytes
  localparam logic [7:0] InsFunctionSet     = 8'h38;
  localparam logic [7:0] InsFunctionSet4Bit = 8'h28;
  localparam logic [7:0] InsDisplayOff      = 8'h08;
  localparam logic [7:0] InsDisplayOn       = 8'h0F;
  localparam logic [7:0] InsDisplayClear    = 8'h01;
  localparam logic [7:0] InsEntryMode       = 8'h06;
  localparam logic [7:0] InsCursorHome      = 8'h02;
  localparam logic       InsSetAddressBit   = 1'b1;

  // Latin-1 umlauts and their display codes
  localparam logic [7:0] ChUpperA  = 8'hC4;
  localparam logic [7:0] ChLowerA  = 8'hE4;
  localparam logic [7:0] ChUpperO  = 8'hD6;
  localparam logic [7:0] ChLowerO  = 8'hF6;
  localparam logic [7:0] LcdCodeA  = 8'd225;
  localparam logic [7:0] LcdCodeO  = 8'd239;

  // Delay classes before a strobe
  localparam logic [2:0] Wait1ms   = 3'd0;
  localparam logic [2:0] Wait15ms  = 3'd1;
  localparam logic [2:0] Wait5ms   = 3'd2;
  localparam logic [2:0] Wait100us = 3'd3;
  localparam logic [2:0] Wait2ms   = 3'd4;

  // Sequencer step counts
  localparam int unsigned StepWidth = 4;
  localparam logic [StepWidth-1:0] StepsOneByte = 4'd2;
  localparam logic [StepWidth-1:0] StepsTwoByte = 4'd4;
  localparam logic [StepWidth-1:0] StepsInit    = 4'd12;

  // Command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] payload;
  } cmd_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic [2:0] wait_class;
    logic [6:0] cursor_now;
    logic       last_transfer;
  } result_t;

  typedef enum logic {
    KindBytes = 1'b0,
    KindInit  = 1'b1
  } desc_kind_e;

  // One classified command as handed to the back end
  typedef struct packed {
    desc_kind_e kind;
    logic       rs_first;
    logic [7:0] byte_first;
    logic       two_bytes;
    logic [7:0] byte_second;
    logic [6:0] cursor;
  } desc_t;

  typedef struct packed {
    logic [3:0] nibble;
    logic [2:0] wait_class;
  } init_step_t;

  // Power-on sequence, one entry per nibble
  function automatic init_step_t init_step(input logic [StepWidth-1:0] idx);
    init_step_t s;
    s = '{nibble: 4'h0, wait_class: Wait1ms};
    unique case (idx)
      4'd0:    s = '{nibble: InsFunctionSet[7:4], wait_class: Wait15ms};
      4'd1:    s = '{nibble: InsFunctionSet[7:4], wait_class: Wait5ms};
      4'd2:    s = '{nibble: InsFunctionSet[7:4], wait_class: Wait100us};
      4'd3:    s = '{nibble: InsFunctionSet4Bit[7:4], wait_class: Wait1ms};
      4'd4:    s = '{nibble: InsDisplayOff[7:4], wait_class: Wait1ms};
      4'd5:    s = '{nibble: InsDisplayOff[3:0], wait_class: Wait1ms};
      4'd6:    s = '{nibble: InsDisplayClear[7:4], wait_class: Wait2ms};
      4'd7:    s = '{nibble: InsDisplayClear[3:0], wait_class: Wait1ms};
      4'd8:    s = '{nibble: InsEntryMode[7:4], wait_class: Wait2ms};
      4'd9:    s = '{nibble: InsEntryMode[3:0], wait_class: Wait1ms};
      4'd10:   s = '{nibble: InsDisplayOn[7:4], wait_class: Wait2ms};
      4'd11:   s = '{nibble: InsDisplayOn[3:0], wait_class: Wait1ms};
      default: s = '{nibble: 4'h0, wait_class: Wait1ms};
    endcase
    return s;
  endfunction

endpackage

// ===== sv/char_lcd_nibble_writer_top.sv =====
// Top level of the character-LCD nibble writer: front end, descriptor queue
// and nibble sequencer. Depends on clnw_pkg, clnw_front, clnw_queue, clnw_back.
`timescale 1ns / 1ps

// Each command becomes a run of 4-bit transfers, high nibble first, with a
// delay class per transfer: characters give two transfers, or four when the
// line-two jump follows; set cursor, clear, home and raw instructions give
// two; initialize gives twelve. Actions 6 and 7 are accepted and dropped.
// The sequencer delivers one transfer per cycle while pop is held and the
// queue is not empty; a two-entry command queue lets the next commands be
// accepted while a command occupies the result side. Configuration
// writes are always ready and take effect on the next command.
module char_lcd_nibble_writer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  clnw_pkg::cmd_t                    cmd_i,
  output logic                              empty,
  input  logic                              pop,
  output clnw_pkg::result_t                 result_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [clnw_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [6:0]                        cfg_data_i
);

  logic            q_full, q_empty, enq, deq, accepted;
  clnw_pkg::desc_t enq_desc, head_desc;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  clnw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (cmd_i),
    .q_full_i    (q_full),
    .accept_o    (accepted),
    .enq_o       (enq),
    .desc_o      (enq_desc),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  clnw_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq && accepted),
    .desc_i  (enq_desc),
    .full_o  (q_full),
    .deq_i   (deq),
    .empty_o (q_empty),
    .desc_o  (head_desc)
  );

  clnw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .desc_i    (head_desc),
    .deq_o     (deq),
    .empty_o   (empty),
    .pop_i     (pop),
    .result_o  (result_o)
  );

endmodule

// ===== sv/clnw_front.sv =====
// Front end: takes commands, tracks the cursor and the configuration registers,
// and turns each command into a descriptor. Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  clnw_pkg::cmd_t                    cmd_i,
  input  logic                              q_full_i,
  output logic                              accept_o,
  output logic                              enq_o,
  output clnw_pkg::desc_t                   desc_o,
  input  logic                              cfg_valid_i,
  input  logic [clnw_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [6:0]                        cfg_data_i
);

  logic [6:0] cursor_q, cursor_d;
  logic [6:0] disp_len_q, line_two_q;
  logic [6:0] cursor_inc;
  logic       line_hit;
  logic [7:0] char_code;
  logic       valid_action;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disp_len_q <= clnw_pkg::DisplayLengthReset;
      line_two_q <= clnw_pkg::LineTwoAddrReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == clnw_pkg::CfgDisplayLength) begin
        disp_len_q <= cfg_data_i;
      end else if (cfg_index_i == clnw_pkg::CfgLineTwoAddr) begin
        line_two_q <= cfg_data_i;
      end
    end
  end

  assign accept_o   = push_i && !q_full_i;
  assign cursor_inc = cursor_q + 7'd1;
  assign line_hit   = (cursor_inc == disp_len_q);

  // Map umlauts to the display's character set
  always_comb begin
    priority if (cmd_i.payload == clnw_pkg::ChUpperA || cmd_i.payload == clnw_pkg::ChLowerA)
    begin
      char_code = clnw_pkg::LcdCodeA;
    end else if (cmd_i.payload == clnw_pkg::ChUpperO ||
                 cmd_i.payload == clnw_pkg::ChLowerO) begin
      char_code = clnw_pkg::LcdCodeO;
    end else begin
      char_code = cmd_i.payload;
    end
  end

  // Classify the command and work out the new cursor
  always_comb begin
    cursor_d     = cursor_q;
    valid_action = 1'b1;
    desc_o       = '{kind: clnw_pkg::KindBytes, rs_first: 1'b0, byte_first: 8'h00,
                     two_bytes: 1'b0, byte_second: {clnw_pkg::InsSetAddressBit, line_two_q},
                     cursor: 7'd0};
    unique case (cmd_i.action)
      clnw_pkg::ActChar: begin
        desc_o.rs_first   = 1'b1;
        desc_o.byte_first = char_code;
        desc_o.two_bytes  = line_hit;
        cursor_d          = line_hit ? line_two_q : cursor_inc;
      end
      clnw_pkg::ActCursor: begin
        desc_o.byte_first = {clnw_pkg::InsSetAddressBit, cmd_i.payload[6:0]};
        cursor_d          = cmd_i.payload[6:0];
      end
      clnw_pkg::ActClear: begin
        desc_o.byte_first = clnw_pkg::InsDisplayClear;
        cursor_d          = 7'd0;
      end
      clnw_pkg::ActHome: begin
        desc_o.byte_first = clnw_pkg::InsCursorHome;
        cursor_d          = 7'd0;
      end
      clnw_pkg::ActRaw: begin
        desc_o.byte_first = cmd_i.payload;
      end
      clnw_pkg::ActInit: begin
        desc_o.kind = clnw_pkg::KindInit;
        cursor_d    = 7'd0;
      end
      default: begin
        valid_action = 1'b0;
      end
    endcase
    desc_o.cursor = cursor_d;
  end

  assign enq_o = accept_o && valid_action;

  // Cursor tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= 7'd0;
    end else if (enq_o) begin
      cursor_q <= cursor_d;
    end
  end

endmodule

// ===== sv/clnw_queue.sv =====
// Short descriptor queue between the front end and the nibble sequencer.
// Depends on clnw_pkg for the descriptor type and depth.
`timescale 1ns / 1ps

module clnw_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            enq_i,
  input  clnw_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            deq_i,
  output logic            empty_o,
  output clnw_pkg::desc_t desc_o
);

  localparam int unsigned CntW = $clog2(clnw_pkg::QueueDepth + 1);

  clnw_pkg::desc_t                   slots_q [clnw_pkg::QueueDepth];
  logic [clnw_pkg::QueuePtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]                   count_q;

  assign full_o  = (count_q == CntW'(clnw_pkg::QueueDepth));
  assign empty_o = (count_q == '0);
  assign desc_o  = slots_q[rd_ptr_q];

  // Store incoming descriptors
  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      slots_q[wr_ptr_q] <= desc_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (enq_i) begin
        wr_ptr_q <= (wr_ptr_q == clnw_pkg::QueuePtrW'(clnw_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (deq_i) begin
        rd_ptr_q <= (rd_ptr_q == clnw_pkg::QueuePtrW'(clnw_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      unique case ({enq_i, deq_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== sv/clnw_back.sv =====
// Back end: steps through the head descriptor into a result register, one
// nibble per cycle while that register is empty or popped. Depends on clnw_pkg.
`timescale 1ns / 1ps

module clnw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  clnw_pkg::desc_t   desc_i,
  output logic              deq_o,
  output logic              empty_o,
  input  logic              pop_i,
  output clnw_pkg::result_t result_o
);

  logic [clnw_pkg::StepWidth-1:0] step_q;
  logic [clnw_pkg::StepWidth-1:0] step_count;
  logic                           out_valid_q;
  clnw_pkg::result_t              out_q, nib;
  clnw_pkg::init_step_t           init_s;
  logic [7:0]                     cur_byte;
  logic                           advance, last_step;

  assign init_s = clnw_pkg::init_step(step_q);

  // Build the nibble for the current step
  always_comb begin
    cur_byte = step_q[1] ? desc_i.byte_second : desc_i.byte_first;
    nib.cursor_now = desc_i.cursor;
    unique case (desc_i.kind)
      clnw_pkg::KindInit: begin
        step_count     = clnw_pkg::StepsInit;
        nib.reg_select = 1'b0;
        nib.nibble     = init_s.nibble;
        nib.wait_class = init_s.wait_class;
      end
      default: begin
        step_count     = desc_i.two_bytes ? clnw_pkg::StepsTwoByte : clnw_pkg::StepsOneByte;
        nib.reg_select = step_q[1] ? 1'b0 : desc_i.rs_first;
        nib.nibble     = step_q[0] ? cur_byte[3:0] : cur_byte[7:4];
        nib.wait_class = clnw_pkg::Wait1ms;
      end
    endcase
    last_step         = (step_q == step_count - 1'b1);
    nib.last_transfer = last_step;
  end

  assign advance  = !q_empty_i && (!out_valid_q || pop_i);
  assign deq_o    = advance && last_step;
  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

  // Hold the result until popped
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= nib;
    end
  end

  // Step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        step_q      <= last_step ? '0 : step_q + 1'b1;
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
